>>> hw/rtl/psgm_pkg.sv
`default_nettype none

package psgm_pkg;

    localparam int SEQ_BITS          = 14;
    localparam int STREAM_BITS       = 2;
    localparam int STREAM_COUNT      = 4;
    localparam int HIST_BINS_DEFAULT = 256;
    localparam int LEN_BITS          = 16;
    localparam int DAY_BITS          = 16;
    localparam int MS_BITS           = 27;
    localparam int TIME_BITS         = 43;
    localparam int SCLK_BITS         = 40;
    localparam int BIN_IDX_BITS      = 8;
    localparam int CNT_BITS          = 32;

    localparam logic [TIME_BITS-1:0] MS_PER_DAY     = 43'd86400000;
    localparam logic [LEN_BITS-1:0]  FULL_SCI_RESET = 16'd952;
    localparam logic [LEN_BITS-1:0]  FULL_HK_RESET  = 16'd192;

    localparam logic [STREAM_BITS-1:0] STREAM_HK    = 2'd0;
    localparam logic [STREAM_BITS-1:0] STREAM_OTHER = 2'd3;

    typedef enum logic {
        ACT_PACKET = 1'b0,
        ACT_READ   = 1'b1
    } t_action;

    typedef enum logic {
        CFG_FULL_SCIENCE      = 1'b0,
        CFG_FULL_HOUSEKEEPING = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        TEV_INSIDE   = 2'd0,
        TEV_FIRST    = 2'd1,
        TEV_EARLIEST = 2'd2,
        TEV_LATEST   = 2'd3
    } t_time_event;

    // A classified word as it travels from the front end to the back end.
    typedef struct packed {
        t_action                 action;
        logic [STREAM_BITS-1:0]  stream;
        logic [SEQ_BITS-1:0]     seq;
        logic                    is_full;
        logic [TIME_BITS-1:0]    ert;
        logic [TIME_BITS-1:0]    scet;
        logic [SCLK_BITS-1:0]    sclk;
        logic [BIN_IDX_BITS-1:0] bin_index;
    } t_item;

endpackage

`default_nettype wire

>>> hw/rtl/psgm_if.sv
`default_nettype none

interface psgm_in_if;
    logic                              valid;
    logic                              ready;
    logic                              action;
    logic [psgm_pkg::STREAM_BITS-1:0]  stream;
    logic [psgm_pkg::SEQ_BITS-1:0]     sequence_req;
    logic [psgm_pkg::LEN_BITS-1:0]     payload_length;
    logic [psgm_pkg::DAY_BITS-1:0]     ert_days;
    logic [psgm_pkg::MS_BITS-1:0]      ert_ms;
    logic [psgm_pkg::DAY_BITS-1:0]     scet_days;
    logic [psgm_pkg::MS_BITS-1:0]      scet_ms;
    logic [psgm_pkg::SCLK_BITS-1:0]    sclk;
    logic [psgm_pkg::BIN_IDX_BITS-1:0] bin_index;

    modport source (output valid, action, stream, sequence_req, payload_length, ert_days,
                    ert_ms, scet_days, scet_ms, sclk, bin_index, input ready);
    modport sink   (input valid, action, stream, sequence_req, payload_length, ert_days,
                    ert_ms, scet_days, scet_ms, sclk, bin_index, output ready);
endinterface

interface psgm_out_if;
    logic                          valid;
    logic                          ready;
    logic                          gap_found;
    logic [psgm_pkg::SEQ_BITS-1:0] gap_length;
    logic                          long_gap;
    logic                          sequence_wrapped;
    logic [1:0]                    ert_event;
    logic [1:0]                    scet_event;
    logic                          skew_seen;
    logic [psgm_pkg::CNT_BITS-1:0] bin_total;
    logic [psgm_pkg::CNT_BITS-1:0] full_total;
    logic [psgm_pkg::CNT_BITS-1:0] fill_total;
    logic [psgm_pkg::CNT_BITS-1:0] expected_total;
    logic [psgm_pkg::CNT_BITS-1:0] skew_total;

    modport source (output valid, gap_found, gap_length, long_gap, sequence_wrapped,
                    ert_event, scet_event, skew_seen, bin_total, full_total, fill_total,
                    expected_total, skew_total, input ready);
    modport sink   (input valid, gap_found, gap_length, long_gap, sequence_wrapped,
                    ert_event, scet_event, skew_seen, bin_total, full_total, fill_total,
                    expected_total, skew_total, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/packet_sequence_gap_monitor_unit.sv
// Path: an accepted word goes through the front, queue, stage-two and output registers.
// Throughput: one word per cycle while results are taken; the histogram read-modify-write
// is pipelined with forwarding. Reset: synchronous, active low; counters, flags and valid
// bits return to their defaults. A clearing sweep then zeroes all 4 x HISTOGRAM_BINS histogram
// entries (1024 by default), accepting no word; configuration writes are taken throughout.
`default_nettype none

module packet_sequence_gap_monitor_unit #(
    parameter int HISTOGRAM_BINS = psgm_pkg::HIST_BINS_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic [psgm_pkg::LEN_BITS-1:0] i_cfg_data,
    psgm_in_if.sink                            i_in,
    psgm_out_if.source                         o_out
);
    import psgm_pkg::*;

    // The front end registers each word, checks its length against the configured full
    // length of its stream and converts both time stamps to milliseconds since day zero.
    // A two-word queue lets the front end keep taking words while the back end stalls.
    // The back end updates the per-stream state, registers the histogram bin it reads,
    // and in its second stage writes the saturated sum back; a word that hits the bin being
    // written takes the new value by forwarding. A final output register drives the port.

    logic  front_valid;
    logic  front_ready;
    t_item front_item;
    logic  queue_valid;
    logic  queue_ready;
    t_item queue_item;
    logic  clear_busy;

    psgm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_hold      (clear_busy),
        .i_in        (i_in),
        .o_valid     (front_valid),
        .i_ready     (front_ready),
        .o_item      (front_item)
    );

    psgm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_item  (front_item),
        .o_valid (queue_valid),
        .i_ready (queue_ready),
        .o_item  (queue_item)
    );

    psgm_back #(
        .HISTOGRAM_BINS (HISTOGRAM_BINS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (queue_valid),
        .o_ready      (queue_ready),
        .i_item       (queue_item),
        .o_clear_busy (clear_busy),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

>>> hw/rtl/psgm_front.sv
`default_nettype none

module psgm_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_index,
    input  wire logic [psgm_pkg::LEN_BITS-1:0]  i_cfg_data,
    input  wire logic                           i_hold,
    psgm_in_if.sink                             i_in,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output psgm_pkg::t_item                     o_item
);
    import psgm_pkg::*;

    logic [LEN_BITS-1:0] r_full_sci;
    logic [LEN_BITS-1:0] r_full_hk;
    logic                r_valid;
    t_item               r_item;
    t_item               n_item;
    logic [LEN_BITS-1:0] full_len;

    assign i_in.ready = !i_hold && (!r_valid || i_ready);

    // Classify the word: full-length test and combined (days, ms) time values.
    always_comb begin
        full_len          = (i_in.stream == STREAM_HK) ? r_full_hk : r_full_sci;
        n_item.action     = t_action'(i_in.action);
        n_item.stream     = i_in.stream;
        n_item.seq        = i_in.sequence_req;
        n_item.is_full    = (i_in.payload_length == full_len);
        n_item.ert        = TIME_BITS'(i_in.ert_days) * MS_PER_DAY + TIME_BITS'(i_in.ert_ms);
        n_item.scet       = TIME_BITS'(i_in.scet_days) * MS_PER_DAY + TIME_BITS'(i_in.scet_ms);
        n_item.sclk       = i_in.sclk;
        n_item.bin_index  = i_in.bin_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_sci <= FULL_SCI_RESET;
            r_full_hk  <= FULL_HK_RESET;
            r_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_FULL_SCIENCE:      r_full_sci <= i_cfg_data;
                    CFG_FULL_HOUSEKEEPING: r_full_hk  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in.ready) begin
                r_valid <= i_in.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

>>> hw/rtl/psgm_queue.sv
`default_nettype none

module psgm_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  psgm_pkg::t_item        i_item,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output psgm_pkg::t_item        o_item
);
    import psgm_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/psgm_back.sv
`default_nettype none

module psgm_back #(
    parameter int HISTOGRAM_BINS = psgm_pkg::HIST_BINS_DEFAULT
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  psgm_pkg::t_item i_item,
    output logic            o_clear_busy,
    psgm_out_if.source      o_out
);
    import psgm_pkg::*;

    localparam int BW    = $clog2(HISTOGRAM_BINS);
    localparam int DEPTH = STREAM_COUNT * HISTOGRAM_BINS;
    localparam int AW    = $clog2(DEPTH);
    localparam int TOPW  = CNT_BITS + SEQ_BITS + 1;

    typedef struct packed {
        t_time_event          ev;
        logic [TIME_BITS-1:0] early;
        logic [TIME_BITS-1:0] late;
    } t_track;

    typedef struct packed {
        logic                gap_found;
        logic [SEQ_BITS-1:0] gap_length;
        logic                long_gap;
        logic                sequence_wrapped;
        t_time_event         ert_event;
        t_time_event         scet_event;
        logic                skew_seen;
        logic [CNT_BITS-1:0] bin_total;
        logic [CNT_BITS-1:0] full_total;
        logic [CNT_BITS-1:0] fill_total;
        logic [CNT_BITS-1:0] expected_total;
        logic [CNT_BITS-1:0] skew_total;
    } t_result;

    function automatic logic [CNT_BITS-1:0] f_sat_inc(input logic [CNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic t_track f_track(input logic v, input logic [TIME_BITS-1:0] e,
                                       input logic [TIME_BITS-1:0] l,
                                       input logic [TIME_BITS-1:0] t);
        t_track r;
        r.ev    = TEV_INSIDE;
        r.early = e;
        r.late  = l;
        if (!v) begin
            r.ev    = TEV_FIRST;
            r.early = t;
            r.late  = t;
        end else if (t < e) begin
            r.ev    = TEV_EARLIEST;
            r.early = t;
        end else if (t > l) begin
            r.ev   = TEV_LATEST;
            r.late = t;
        end
        return r;
    endfunction

    // Per-stream state, and the SCLK tracking shared by all streams.
    logic                 r_seen      [STREAM_COUNT];
    logic [SEQ_BITS-1:0]  r_first_seq [STREAM_COUNT];
    logic [SEQ_BITS-1:0]  r_last_seq  [STREAM_COUNT];
    logic [CNT_BITS-1:0]  r_wrap      [STREAM_COUNT];
    logic [CNT_BITS-1:0]  r_full      [STREAM_COUNT];
    logic [CNT_BITS-1:0]  r_fill      [STREAM_COUNT];
    logic                 r_ert_v     [STREAM_COUNT];
    logic [TIME_BITS-1:0] r_ert_e     [STREAM_COUNT];
    logic [TIME_BITS-1:0] r_ert_l     [STREAM_COUNT];
    logic                 r_scet_v    [STREAM_COUNT];
    logic [TIME_BITS-1:0] r_scet_e    [STREAM_COUNT];
    logic [TIME_BITS-1:0] r_scet_l    [STREAM_COUNT];
    logic [SCLK_BITS-1:0] r_prev_sclk;
    logic [CNT_BITS-1:0]  r_skew;

    // Histogram memory and its clearing sweep.
    logic [CNT_BITS-1:0] r_hist [DEPTH];
    logic [CNT_BITS-1:0] r_rd;
    logic                r_clr_busy;
    logic [AW-1:0]       r_clr_addr;

    // Second stage and output register.
    logic                r_s2_valid;
    t_result             r_s2;
    logic                r_s2_write;
    logic                r_s2_bin_ok;
    logic [AW-1:0]       r_s2_addr;
    logic [SEQ_BITS-1:0] r_s2_gap;
    logic                r_fwd_hit;
    logic [CNT_BITS-1:0] r_fwd_val;
    logic                r_out_valid;
    t_result             r_out;

    logic                   adv;
    logic                   pop;
    logic                   pkt;
    logic [STREAM_BITS-1:0] s;
    logic                   skew;
    t_track                 ert_t;
    t_track                 scet_t;
    logic [SEQ_BITS-1:0]    want;
    logic                   wrapped;
    logic                   gap_hit;
    logic [SEQ_BITS-1:0]    gap;
    logic                   long_gap;
    logic [BW-1:0]          bin;
    logic                   bin_ok;
    logic [AW-1:0]          rd_addr;
    logic [TOPW-1:0]        top;
    logic [TOPW-1:0]        span;
    t_result                n_s2;
    logic [CNT_BITS-1:0]    hist;
    logic [CNT_BITS:0]      hist_sum;
    logic [CNT_BITS-1:0]    hist_new;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [CNT_BITS-1:0]    mem_wdata;
    t_result                n_out;

    assign adv          = !r_out_valid || o_out.ready;
    assign o_ready      = adv && !r_clr_busy;
    assign pop          = i_valid && o_ready;
    assign o_clear_busy = r_clr_busy;

    // First stage: evaluate the word against the per-stream state.
    always_comb begin
        s        = i_item.stream;
        pkt      = (i_item.action == ACT_PACKET);
        skew     = (r_prev_sclk >= i_item.sclk);
        ert_t    = f_track(r_ert_v[s], r_ert_e[s], r_ert_l[s], i_item.ert);
        scet_t   = f_track(r_scet_v[s], r_scet_e[s], r_scet_l[s], i_item.scet);
        want     = r_last_seq[s] + 1'b1;
        wrapped  = r_seen[s] && (r_last_seq[s] > i_item.seq);
        gap_hit  = r_seen[s] && (want != i_item.seq);
        gap      = i_item.seq - want;
        long_gap = (32'(gap) >= 32'(HISTOGRAM_BINS - 1));
        bin      = long_gap ? BW'(HISTOGRAM_BINS - 1) : BW'(gap);
        bin_ok   = (32'(i_item.bin_index) < 32'(HISTOGRAM_BINS));
        if (pkt) begin
            rd_addr = AW'(s) * AW'(HISTOGRAM_BINS) + AW'(bin);
        end else begin
            rd_addr = AW'(s) * AW'(HISTOGRAM_BINS) + AW'(BW'(i_item.bin_index));
        end
        top  = TOPW'({r_wrap[s], SEQ_BITS'(0)}) + TOPW'(r_last_seq[s]) + TOPW'(1);
        span = (top >= TOPW'(r_first_seq[s])) ? top - TOPW'(r_first_seq[s]) : '0;

        n_s2 = '0;
        if (pkt) begin
            n_s2.gap_found        = gap_hit;
            n_s2.gap_length       = gap_hit ? gap : '0;
            n_s2.long_gap         = gap_hit && long_gap;
            n_s2.sequence_wrapped = wrapped;
            n_s2.ert_event        = ert_t.ev;
            n_s2.scet_event       = scet_t.ev;
            n_s2.skew_seen        = skew;
        end else begin
            n_s2.full_total = r_full[s];
            n_s2.fill_total = r_fill[s];
            if (r_seen[s]) begin
                n_s2.expected_total = (|span[TOPW-1:CNT_BITS]) ? '1 : span[CNT_BITS-1:0];
            end
            n_s2.skew_total = r_skew;
        end
    end

    // Second stage: histogram read-modify-write, forwarded from the word ahead.
    always_comb begin
        hist      = r_fwd_hit ? r_fwd_val : r_rd;
        hist_sum  = {1'b0, hist} + (CNT_BITS + 1)'(r_s2_gap);
        hist_new  = hist_sum[CNT_BITS] ? '1 : hist_sum[CNT_BITS-1:0];
        mem_we    = r_clr_busy || (adv && r_s2_valid && r_s2_write);
        mem_waddr = r_clr_busy ? r_clr_addr : r_s2_addr;
        mem_wdata = r_clr_busy ? '0 : hist_new;
        n_out           = r_s2;
        n_out.bin_total = r_s2_bin_ok ? hist : '0;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hist[mem_waddr] <= mem_wdata;
        end
        if (adv) begin
            r_rd <= r_hist[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < STREAM_COUNT; i++) begin
                r_seen[i]      <= 1'b0;
                r_first_seq[i] <= '0;
                r_last_seq[i]  <= '0;
                r_wrap[i]      <= '0;
                r_full[i]      <= '0;
                r_fill[i]      <= '0;
                r_ert_v[i]     <= 1'b0;
                r_ert_e[i]     <= '0;
                r_ert_l[i]     <= '0;
                r_scet_v[i]    <= 1'b0;
                r_scet_e[i]    <= '0;
                r_scet_l[i]    <= '0;
            end
            r_prev_sclk <= '0;
            r_skew      <= '0;
        end else if (pop && pkt) begin
            r_prev_sclk <= i_item.sclk;
            if (skew) begin
                r_skew <= f_sat_inc(r_skew);
            end
            if (s != STREAM_OTHER) begin
                if (i_item.is_full) begin
                    r_full[s] <= f_sat_inc(r_full[s]);
                end else begin
                    r_fill[s] <= f_sat_inc(r_fill[s]);
                end
            end
            r_ert_v[s]  <= 1'b1;
            r_ert_e[s]  <= ert_t.early;
            r_ert_l[s]  <= ert_t.late;
            r_scet_v[s] <= 1'b1;
            r_scet_e[s] <= scet_t.early;
            r_scet_l[s] <= scet_t.late;
            if (!r_seen[s]) begin
                r_seen[s]      <= 1'b1;
                r_first_seq[s] <= i_item.seq;
            end
            if (wrapped) begin
                r_wrap[s] <= f_sat_inc(r_wrap[s]);
            end
            r_last_seq[s] <= i_item.seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_s2_valid  <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (adv) begin
                r_s2_valid  <= pop;
                r_fwd_hit   <= pop && r_s2_valid && r_s2_write && (rd_addr == r_s2_addr);
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2        <= n_s2;
            r_s2_write  <= pkt && gap_hit;
            r_s2_bin_ok <= !pkt && bin_ok;
            r_s2_addr   <= rd_addr;
            r_s2_gap    <= gap;
            r_fwd_val   <= hist_new;
            r_out       <= n_out;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.gap_found        = r_out.gap_found;
    assign o_out.gap_length       = r_out.gap_length;
    assign o_out.long_gap         = r_out.long_gap;
    assign o_out.sequence_wrapped = r_out.sequence_wrapped;
    assign o_out.ert_event        = r_out.ert_event;
    assign o_out.scet_event       = r_out.scet_event;
    assign o_out.skew_seen        = r_out.skew_seen;
    assign o_out.bin_total        = r_out.bin_total;
    assign o_out.full_total       = r_out.full_total;
    assign o_out.fill_total       = r_out.fill_total;
    assign o_out.expected_total   = r_out.expected_total;
    assign o_out.skew_total       = r_out.skew_total;

`ifndef SYNTHESIS
    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !pop) else $error("word taken during histogram clear");
    a_fwd_needs_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> r_s2_valid) else $error("forward hit without a word in stage two");
    a_s2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !adv) |=> r_s2_valid) else $error("stalled stage two lost its word");
    a_clear_no_write_race: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_s2_valid) else $error("histogram write during clear");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import psgm_pkg::*;

    // One input word as the sender offers it.
    typedef struct {
        t_action                 action;
        bit [STREAM_BITS-1:0]    stream;
        bit [SEQ_BITS-1:0]       seq;
        bit [LEN_BITS-1:0]       len;
        bit [DAY_BITS-1:0]       ert_days;
        bit [MS_BITS-1:0]        ert_ms;
        bit [DAY_BITS-1:0]       scet_days;
        bit [MS_BITS-1:0]        scet_ms;
        bit [SCLK_BITS-1:0]      sclk;
        bit [BIN_IDX_BITS-1:0]   bin_index;
    } t_word;

    // One result word as the block returns it.
    typedef struct {
        bit                  gap_found;
        bit [SEQ_BITS-1:0]   gap_length;
        bit                  long_gap;
        bit                  wrapped;
        t_time_event         ert_event;
        t_time_event         scet_event;
        bit                  skew_seen;
        bit [CNT_BITS-1:0]   bin_total;
        bit [CNT_BITS-1:0]   full_total;
        bit [CNT_BITS-1:0]   fill_total;
        bit [CNT_BITS-1:0]   expected_total;
        bit [CNT_BITS-1:0]   skew_total;
    } t_stats;

    localparam int BINS      = HIST_BINS_DEFAULT;
    localparam int WDOG_MAX  = 5000;
    localparam int DRAIN_CYC = 12;

    // Keeps its own copy of the monitor state, predicts the result of every
    // accepted word and compares the returned results in order.
    class gap_scoreboard;
        bit [LEN_BITS-1:0]  full_sci;
        bit [LEN_BITS-1:0]  full_hk;
        bit                 seen     [STREAM_COUNT];
        bit [SEQ_BITS-1:0]  first_sq [STREAM_COUNT];
        bit [SEQ_BITS-1:0]  last_sq  [STREAM_COUNT];
        bit [CNT_BITS-1:0]  wraps    [STREAM_COUNT];
        bit [CNT_BITS-1:0]  fulls    [STREAM_COUNT];
        bit [CNT_BITS-1:0]  fills    [STREAM_COUNT];
        bit [CNT_BITS-1:0]  hist     [STREAM_COUNT*BINS];
        bit                 ert_ok   [STREAM_COUNT];
        bit [TIME_BITS-1:0] ert_lo   [STREAM_COUNT];
        bit [TIME_BITS-1:0] ert_hi   [STREAM_COUNT];
        bit                 scet_ok  [STREAM_COUNT];
        bit [TIME_BITS-1:0] scet_lo  [STREAM_COUNT];
        bit [TIME_BITS-1:0] scet_hi  [STREAM_COUNT];
        bit [SCLK_BITS-1:0] sclk_prev;
        bit [CNT_BITS-1:0]  skews;
        t_stats             pending_stats[$];
        int                 errors;

        function new();
            full_sci = FULL_SCI_RESET;
            full_hk  = FULL_HK_RESET;
            foreach (seen[i]) begin
                seen[i] = 0; first_sq[i] = 0; last_sq[i] = 0; wraps[i] = 0;
                fulls[i] = 0; fills[i] = 0; ert_ok[i] = 0; scet_ok[i] = 0;
                ert_lo[i] = 0; ert_hi[i] = 0; scet_lo[i] = 0; scet_hi[i] = 0;
            end
            foreach (hist[i]) hist[i] = 0;
            sclk_prev = 0;
            skews     = 0;
            errors    = 0;
        endfunction

        function bit [CNT_BITS-1:0] sat_inc(bit [CNT_BITS-1:0] a, longint unsigned b);
            longint unsigned s;
            s = longint'(a) + b;
            return (s > 64'hFFFF_FFFF) ? '1 : s[CNT_BITS-1:0];
        endfunction

        function void set_reg(t_cfg_index idx, bit [LEN_BITS-1:0] val);
            if (idx == CFG_FULL_SCIENCE) full_sci = val;
            else full_hk = val;
        endfunction

        // Bounds tracking for one of the two time stamps (ERT or SCET) of one stream.
        function t_time_event track(ref bit ok, ref bit [TIME_BITS-1:0] lo,
                                    ref bit [TIME_BITS-1:0] hi, input bit [TIME_BITS-1:0] t);
            if (!ok) begin
                ok = 1; lo = t; hi = t;
                return TEV_FIRST;
            end
            if (t < lo) begin
                lo = t;
                return TEV_EARLIEST;
            end
            if (t > hi) begin
                hi = t;
                return TEV_LATEST;
            end
            return TEV_INSIDE;
        endfunction

        function void note_word(t_word w);
            t_stats r;
            int s;
            bit [TIME_BITS-1:0] ert, scet;
            bit [SEQ_BITS-1:0] want, gap;
            int b;
            longint unsigned top, e;
            r = '{ert_event: TEV_INSIDE, scet_event: TEV_INSIDE, default: '0};
            s = w.stream;
            if (w.action == ACT_PACKET) begin
                ert  = TIME_BITS'(w.ert_days) * MS_PER_DAY + TIME_BITS'(w.ert_ms);
                scet = TIME_BITS'(w.scet_days) * MS_PER_DAY + TIME_BITS'(w.scet_ms);
                if (sclk_prev >= w.sclk) begin
                    skews = sat_inc(skews, 1);
                    r.skew_seen = 1;
                end
                sclk_prev = w.sclk;
                if (w.stream != STREAM_OTHER) begin
                    if (w.len == ((w.stream == STREAM_HK) ? full_hk : full_sci))
                        fulls[s] = sat_inc(fulls[s], 1);
                    else
                        fills[s] = sat_inc(fills[s], 1);
                end
                r.ert_event  = track(ert_ok[s], ert_lo[s], ert_hi[s], ert);
                r.scet_event = track(scet_ok[s], scet_lo[s], scet_hi[s], scet);
                if (!seen[s]) begin
                    seen[s]     = 1;
                    first_sq[s] = w.seq;
                end else begin
                    want = last_sq[s] + 1'b1;
                    if (last_sq[s] > w.seq) begin
                        wraps[s]  = sat_inc(wraps[s], 1);
                        r.wrapped = 1;
                    end
                    if (want != w.seq) begin
                        gap = w.seq - want;
                        b = (gap < BINS - 1) ? int'(gap) : BINS - 1;
                        hist[s*BINS+b] = sat_inc(hist[s*BINS+b], gap);
                        r.gap_found  = 1;
                        r.gap_length = gap;
                        r.long_gap   = (gap >= BINS - 1);
                    end
                end
                last_sq[s] = w.seq;
            end else begin
                r.bin_total  = hist[s*BINS+int'(w.bin_index)];
                r.full_total = fulls[s];
                r.fill_total = fills[s];
                if (seen[s]) begin
                    top = (longint'(wraps[s]) << SEQ_BITS) + last_sq[s] + 1;
                    e   = (top >= first_sq[s]) ? top - first_sq[s] : 0;
                    r.expected_total = (e > 64'hFFFF_FFFF) ? '1 : e[CNT_BITS-1:0];
                end
                r.skew_total = skews;
            end
            pending_stats.push_back(r);
        endfunction

        function void cmp(string fld, longint unsigned exp_v, longint unsigned act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, fld, exp_v, act_v);
            end
        endfunction

        function void check_result(t_stats a);
            t_stats x;
            if (pending_stats.size() == 0) begin
                errors++;
                $display("%0t: result word with nothing expected", $time);
                return;
            end
            x = pending_stats.pop_front();
            cmp("gap_found",        x.gap_found,      a.gap_found);
            cmp("gap_length",       x.gap_length,     a.gap_length);
            cmp("long_gap",         x.long_gap,       a.long_gap);
            cmp("sequence_wrapped", x.wrapped,        a.wrapped);
            cmp("ert_event",        x.ert_event,      a.ert_event);
            cmp("scet_event",       x.scet_event,     a.scet_event);
            cmp("skew_seen",        x.skew_seen,      a.skew_seen);
            cmp("bin_total",        x.bin_total,      a.bin_total);
            cmp("full_total",       x.full_total,     a.full_total);
            cmp("fill_total",       x.fill_total,     a.fill_total);
            cmp("expected_total",   x.expected_total, a.expected_total);
            cmp("skew_total",       x.skew_total,     a.skew_total);
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    logic                cfg_index;
    logic [LEN_BITS-1:0] cfg_data;

    psgm_in_if  in_if ();
    psgm_out_if out_if ();

    packet_sequence_gap_monitor_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_if.sink),
        .o_out       (out_if.source)
    );

    gap_scoreboard sb = new();

    // Idle percentages of the two sides and a pending receiver hold-off.
    int unsigned src_idle_pct  = 0;
    int unsigned sink_idle_pct = 0;
    int          sink_hold     = 0;
    int          quiet_cycles  = 0;

    // Sequence that would follow without loss, per stream, and a running SCLK.
    bit [SEQ_BITS-1:0]  next_seq [STREAM_COUNT];
    bit [SCLK_BITS-1:0] sclk_run;
    bit [DAY_BITS-1:0]  base_day;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: checks every accepted result word and decides its ready for
    // the next cycle, honoring a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                sb.check_result('{out_if.gap_found, out_if.gap_length, out_if.long_gap,
                                  out_if.sequence_wrapped, t_time_event'(out_if.ert_event),
                                  t_time_event'(out_if.scet_event), out_if.skew_seen,
                                  out_if.bin_total, out_if.full_total, out_if.fill_total,
                                  out_if.expected_total, out_if.skew_total});
            end
            if (sink_hold > 0) begin
                sink_hold--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Watchdog: the run is declared hung when no word moves on either side
    // for too long. The post-reset histogram clear fits well inside the limit.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles > WDOG_MAX) begin
                $display("packet_sequence_gap_monitor_unit verification failed");
                $finish;
            end
        end
    end

    // Offers one word, with random idle cycles ahead of it, and notes it in
    // the scoreboard once the block has taken it. Valid stays high afterwards
    // so that back-to-back words never drop it within one time step.
    task automatic send_word(t_word w);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.action         <= w.action;
        in_if.stream         <= w.stream;
        in_if.sequence_req   <= w.seq;
        in_if.payload_length <= w.len;
        in_if.ert_days       <= w.ert_days;
        in_if.ert_ms         <= w.ert_ms;
        in_if.scet_days      <= w.scet_days;
        in_if.scet_ms        <= w.scet_ms;
        in_if.sclk           <= w.sclk;
        in_if.bin_index      <= w.bin_index;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_word(w);
    endtask

    // Waits until every expected result has come, with valid low meanwhile.
    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_stats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // Register writes happen only while the block is drained. The enable is
    // dropped for one cycle after each write.
    task automatic write_reg(t_cfg_index idx, bit [LEN_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    function automatic t_word make_packet(bit [STREAM_BITS-1:0] s, bit [SEQ_BITS-1:0] sq,
                                          bit [LEN_BITS-1:0] len, bit [SCLK_BITS-1:0] ck);
        t_word w;
        w.action    = ACT_PACKET;
        w.stream    = s;
        w.seq       = sq;
        w.len       = len;
        w.ert_days  = base_day + DAY_BITS'($urandom_range(3));
        w.ert_ms    = MS_BITS'($urandom_range(86399999));
        w.scet_days = base_day + DAY_BITS'($urandom_range(3));
        w.scet_ms   = MS_BITS'($urandom_range(86399999));
        w.sclk      = ck;
        w.bin_index = BIN_IDX_BITS'($urandom);
        return w;
    endfunction

    function automatic t_word make_read(bit [STREAM_BITS-1:0] s, bit [BIN_IDX_BITS-1:0] b);
        t_word w;
        w = make_packet(s, SEQ_BITS'($urandom), LEN_BITS'($urandom),
                        SCLK_BITS'({$urandom, $urandom}));
        w.action    = ACT_READ;
        w.bin_index = b;
        return w;
    endfunction

    // Random word: mostly in-order packets with occasional losses, repeats,
    // wild sequences and clock skew, plus reads of the bins likely to be hit.
    function automatic t_word random_word();
        t_word w;
        bit [STREAM_BITS-1:0] s;
        bit [SEQ_BITS-1:0] sq;
        bit [LEN_BITS-1:0] len;
        int unsigned pick;
        s = STREAM_BITS'($urandom);
        if ($urandom_range(99) < 25) begin
            pick = $urandom_range(9);
            return make_read(s, (pick < 6) ? BIN_IDX_BITS'($urandom_range(8))
                                : (pick < 8) ? BIN_IDX_BITS'(BINS - 1)
                                : BIN_IDX_BITS'($urandom));
        end
        pick = $urandom_range(99);
        if (pick < 65)      sq = next_seq[s];
        else if (pick < 82) sq = next_seq[s] + SEQ_BITS'($urandom_range(1, 8));
        else if (pick < 88) sq = next_seq[s] - 1'b1;
        else if (pick < 93) sq = next_seq[s] + SEQ_BITS'($urandom_range(250, 600));
        else                sq = SEQ_BITS'($urandom);
        next_seq[s] = sq + 1'b1;
        pick = $urandom_range(9);
        len = (pick < 4) ? sb.full_sci : (pick < 7) ? sb.full_hk : LEN_BITS'($urandom);
        if ($urandom_range(9) == 0) sclk_run = SCLK_BITS'({$urandom, $urandom});
        else if ($urandom_range(9) == 0) sclk_run = sclk_run - SCLK_BITS'($urandom_range(5));
        else sclk_run = sclk_run + SCLK_BITS'($urandom_range(1, 1000));
        w = make_packet(s, sq, len, sclk_run);
        if ($urandom_range(19) == 0) begin
            w.ert_days  = DAY_BITS'($urandom);
            w.scet_days = DAY_BITS'($urandom);
        end
        return w;
    endfunction

    initial begin : stimulus
        int n;
        int unsigned phase_src [3] = '{32, 48, 0};
        int unsigned phase_sink[3] = '{48, 32, 0};
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_FULL_SCIENCE;
        cfg_data        = '0;
        in_if.valid     = 1'b0;
        in_if.action    = ACT_PACKET;
        in_if.stream    = '0;
        in_if.sequence_req   = '0;
        in_if.payload_length = '0;
        in_if.ert_days  = '0;
        in_if.ert_ms    = '0;
        in_if.scet_days = '0;
        in_if.scet_ms   = '0;
        in_if.sclk      = '0;
        in_if.bin_index = '0;
        foreach (next_seq[i]) next_seq[i] = SEQ_BITS'($urandom);
        sclk_run = 40'd5000;
        base_day = 16'd9000;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Reads before any packet show never-seen streams as
        // zero; the first packet carries SCLK zero and so counts as skew.
        send_word(make_read(2'd1, 8'd0));
        send_word(make_packet(STREAM_HK, 14'd100, FULL_HK_RESET, 40'd0));
        send_word(make_packet(STREAM_HK, 14'd101, 16'd0, 40'd10));
        send_word(make_packet(STREAM_HK, 14'd101, 16'hFFFF, 40'd10));      // repeat, skew
        send_word(make_packet(STREAM_HK, 14'd105, FULL_HK_RESET, 40'd20)); // small gap
        send_word(make_packet(STREAM_HK, 14'd2, FULL_HK_RESET, 40'd30));   // wrap with loss
        send_word(make_packet(2'd1, 14'h3FFF, FULL_SCI_RESET, 40'd40));
        send_word(make_packet(2'd1, 14'd0, FULL_SCI_RESET, 40'd50));       // clean wrap
        send_word(make_packet(2'd1, 14'd255, 16'd951, 40'd60));            // gap of 254
        send_word(make_packet(2'd1, 14'd511, 16'd953, 40'h FF_FFFF_FFFF)); // gap of 255
        send_word(make_packet(2'd2, 14'd0, FULL_SCI_RESET, 40'd1));
        send_word(make_packet(STREAM_OTHER, 14'h3FFF, 16'hFFFF, 40'd2));
        send_word(make_packet(STREAM_OTHER, 14'd7, 16'd0, 40'd3));
        begin
            t_word w;
            w = make_packet(2'd2, 14'd1, 16'd0, 40'd4);
            w.ert_days = 16'hFFFF; w.ert_ms = 27'd86399999;
            w.scet_days = 16'd0;   w.scet_ms = 27'd0;
            send_word(w);
            w = make_packet(2'd2, 14'd2, 16'd0, 40'd5);
            w.ert_days = 16'd0;    w.ert_ms = 27'd0;
            w.scet_days = 16'hFFFF; w.scet_ms = 27'd86399999;
            send_word(w);
        end
        send_word(make_read(STREAM_HK, 8'd0));
        send_word(make_read(STREAM_HK, 8'd3));
        send_word(make_read(2'd1, 8'd254));
        send_word(make_read(2'd1, 8'hFF));
        send_word(make_read(2'd2, 8'd0));
        send_word(make_read(STREAM_OTHER, 8'hFF));
        send_word(make_read(STREAM_OTHER, 8'd9));
        drain();

        // Random phases: each idling pattern with its own register setting,
        // extremes included. The sender pause before each write covers the
        // wait-for-empty case.
        for (int p = 0; p < 3; p++) begin
            src_idle_pct  = phase_src[p];
            sink_idle_pct = phase_sink[p];
            case (p)
                0: begin
                    write_reg(CFG_FULL_SCIENCE, 16'd0);
                    write_reg(CFG_FULL_HOUSEKEEPING, 16'hFFFF);
                end
                1: begin
                    write_reg(CFG_FULL_SCIENCE, 16'hFFFF);
                    write_reg(CFG_FULL_HOUSEKEEPING, 16'd0);
                end
                default: begin
                    write_reg(CFG_FULL_SCIENCE, LEN_BITS'($urandom));
                    write_reg(CFG_FULL_HOUSEKEEPING, LEN_BITS'($urandom));
                end
            endcase
            for (n = 0; n < 200; n++) begin
                // In the last phase the receiver holds off for a long stretch
                // while words keep coming, so the pipeline fills and stalls.
                if (p == 2 && n == 40) sink_hold = 300;
                send_word(random_word());
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending_stats.size() == 0) begin
            $display("packet_sequence_gap_monitor_unit verification clean");
        end else begin
            $display("packet_sequence_gap_monitor_unit verification failed");
        end
        $finish;
    end
endmodule

>>> packet_sequence_gap_monitor_unit.f
hw/rtl/psgm_pkg.sv
hw/rtl/psgm_if.sv
hw/rtl/psgm_front.sv
hw/rtl/psgm_queue.sv
hw/rtl/psgm_back.sv
hw/rtl/packet_sequence_gap_monitor_unit.sv
tb/sv/tb.sv
